// ----- sv/pgl_pkg.sv -----
// ----------------------------------------------------------------------------
// pgl_pkg
// Shared constants, types and arithmetic helpers for the palette gradient
// lookup block.
// ----------------------------------------------------------------------------
package pgl_pkg;

  // Palette geometry and number formats.
  localparam int PALETTE_DEPTH   = 16;
  localparam int FRACTION_BITS   = 8;
  localparam int LOC_W           = 24;
  localparam int INT_W           = LOC_W - FRACTION_BITS;
  localparam int COLOR_W         = 8;
  localparam int RGB_W           = 3 * COLOR_W;
  localparam int PROD_W          = 2 * COLOR_W;
  localparam int ENTRY_W         = 4;
  localparam int SIZE_W          = 5;
  localparam int ADDR_W          = $clog2(PALETTE_DEPTH);
  localparam int CNT_W           = $clog2(PALETTE_DEPTH + 1);

  // Remainder pipeline: a few dividend bits are retired in each stage.
  localparam int BITS_PER_STAGE  = 4;
  localparam int DIV_STAGES      = (INT_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int DIV_W           = DIV_STAGES * BITS_PER_STAGE;

  localparam logic [COLOR_W-1:0] COLOR_MAX = 8'hFF;

  // Request command codes.
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS   = 2'd1;

  // Request as it travels down the remainder pipeline.
  typedef struct packed {
    logic                     cmd;
    logic                     neg;
    logic [FRACTION_BITS-1:0] frac;
    logic [ENTRY_W-1:0]       entry_index;
    logic [RGB_W-1:0]         rgb;
  } pgl_item_t;

  // One restoring step of the remainder: shift in a dividend bit, subtract
  // the divisor when it fits. The remainder stays below the divisor.
  function automatic logic [CNT_W-1:0] rem_step(input logic [CNT_W-1:0] rem,
                                                input logic din,
                                                input logic [CNT_W-1:0] size);
    logic [CNT_W:0] ext;
    ext = {rem, din};
    if (ext >= {1'b0, size}) begin
      ext = ext - {1'b0, size};
    end
    return ext[CNT_W-1:0];
  endfunction

  // Exact floor(x / 255) for any product of two 8-bit values.
  function automatic logic [COLOR_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] s;
    s = {1'b0, x} + (PROD_W + 1)'(x[PROD_W-1:COLOR_W]) + (PROD_W + 1)'(1);
    return s[PROD_W-1:COLOR_W];
  endfunction

  // Blend weight: floor(255 * frac / 2^FRACTION_BITS).
  function automatic logic [COLOR_W-1:0] transition(input logic [FRACTION_BITS-1:0] frac);
    logic [COLOR_W+FRACTION_BITS-1:0] p;
    p = frac * COLOR_MAX;
    return p[COLOR_W+FRACTION_BITS-1:FRACTION_BITS];
  endfunction

  // Legal palette size: zero acts as one, oversize saturates at the depth.
  function automatic logic [CNT_W-1:0] clamp_size(input logic [SIZE_W-1:0] raw);
    logic [CNT_W-1:0] s;
    if (raw == '0) begin
      s = CNT_W'(1);
    end else if (int'(raw) > PALETTE_DEPTH) begin
      s = CNT_W'(PALETTE_DEPTH);
    end else begin
      s = CNT_W'(raw);
    end
    return s;
  endfunction

endpackage

// ----- sv/pgl_if.sv -----
// ----------------------------------------------------------------------------
// pgl_if
// Channel interfaces of the palette gradient lookup block: request channel,
// color result channel and configuration write channel.
// ----------------------------------------------------------------------------

// Request channel: palette writes and location lookups.
interface pgl_req_if import pgl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic signed [LOC_W-1:0]  location;
  logic [ENTRY_W-1:0]       entry_index;
  logic [COLOR_W-1:0]       entry_red;
  logic [COLOR_W-1:0]       entry_green;
  logic [COLOR_W-1:0]       entry_blue;

  modport source (output valid, cmd, location, entry_index, entry_red, entry_green,
                  entry_blue, input ready);
  modport sink (input valid, cmd, location, entry_index, entry_red, entry_green,
                entry_blue, output ready);
endinterface

// Result channel: one blended color per lookup.
interface pgl_color_if import pgl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] out_red;
  logic [COLOR_W-1:0] out_green;
  logic [COLOR_W-1:0] out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

// Configuration write channel.
interface pgl_cfg_if import pgl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/pgl_ram.sv -----
// ----------------------------------------------------------------------------
// pgl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pgl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/palette_gradient_lookup_top.sv -----
// ----------------------------------------------------------------------------
// palette_gradient_lookup_top
// Palette color lookup with linear blending between neighboring entries.
// ----------------------------------------------------------------------------
// The block accepts one request per clock while no stage is stalled and
// returns one color for each lookup request; palette write requests return
// nothing. A lookup passes from acceptance to a valid result through the
// remainder pipeline that wraps the default 16.8 location into the palette,
// one registered palette read, and three registered stages for blending and
// brightness. The palette lives
// in two copies of a 16-entry RAM so that an entry and its neighbor are read
// in the same cycle. Writes land at the point where lookups read, so a
// lookup always sees every write requested before it. Palette entries have no
// reset value and need no clearing after reset. Each stage holds its request
// while the next one is full, so bubbles are squeezed out under back-pressure.
module palette_gradient_lookup_top
  import pgl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  pgl_req_if.sink     lookup,
  pgl_color_if.source color,
  pgl_cfg_if.sink     cfg
);

  // Configuration registers.
  logic [CNT_W-1:0]   size;
  logic [COLOR_W-1:0] brightness;

  // Remainder pipeline.
  logic                div_valid [0:DIV_STAGES];
  pgl_item_t           div_item  [0:DIV_STAGES];
  logic [DIV_W-1:0]    div_shift [0:DIV_STAGES];
  logic [CNT_W-1:0]    div_rem   [0:DIV_STAGES];
  logic [CNT_W-1:0]    div_rem_next [1:DIV_STAGES];
  logic                div_mv    [0:DIV_STAGES+1];

  // Index, read and blend stages.
  logic [CNT_W-1:0]         idx1_full;
  logic [CNT_W-1:0]         idx2_full;
  logic [CNT_W-1:0]         idx1_inc;
  logic                     ram_we;
  logic [RGB_W-1:0]         rd_c1;
  logic [RGB_W-1:0]         rd_c2;
  logic                     rd_valid;
  logic [FRACTION_BITS-1:0] rd_frac;
  logic [COLOR_W-1:0]       rd_t;
  logic                     mu_valid;
  logic [COLOR_W-1:0]       mu_a    [3];
  logic [PROD_W-1:0]        mu_pa   [3];
  logic [PROD_W-1:0]        mu_pb   [3];
  logic [COLOR_W-1:0]       mu_c    [3];
  logic                     sc_valid;
  logic [PROD_W-1:0]        sc_prod [3];
  logic                     op_valid;
  logic [COLOR_W-1:0]       op_color [3];
  logic                     mv_rd;
  logic                     mv_mu;
  logic                     mv_sc;
  logic                     mv_op;

  logic signed [INT_W-1:0]  loc_int;
  logic [INT_W-1:0]         loc_abs;
  pgl_item_t                item_in;

  // Configuration writes; indexes beyond the register list are ignored.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size       <= CNT_W'(1);
      brightness <= COLOR_MAX;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_PALETTE_SIZE: size       <= clamp_size(cfg.data[SIZE_W-1:0]);
        CFG_BRIGHTNESS:   brightness <= cfg.data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage advance: a stage takes a new request when it is empty or its
  // occupant moves on.
  always_comb begin
    mv_op = !op_valid || color.ready;
    mv_sc = !sc_valid || mv_op;
    mv_mu = !mu_valid || mv_sc;
    mv_rd = !rd_valid || mv_mu;
    div_mv[DIV_STAGES+1] = mv_rd;
    for (int k = DIV_STAGES; k >= 0; k--) begin
      div_mv[k] = !div_valid[k] || div_mv[k+1];
    end
  end

  assign lookup.ready = div_mv[0];

  // Split the location: magnitude of the integer part plus its sign.
  always_comb begin
    loc_int             = lookup.location[LOC_W-1:FRACTION_BITS];
    loc_abs             = loc_int[INT_W-1] ? INT_W'(-loc_int) : INT_W'(loc_int);
    item_in.cmd         = lookup.cmd;
    item_in.neg         = loc_int[INT_W-1];
    item_in.frac        = lookup.location[FRACTION_BITS-1:0];
    item_in.entry_index = lookup.entry_index;
    item_in.rgb         = {lookup.entry_red, lookup.entry_green, lookup.entry_blue};
  end

  // Remainder steps of each stage: retire BITS_PER_STAGE dividend bits.
  always_comb begin
    logic [CNT_W-1:0] rem;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      rem = div_rem[k-1];
      for (int j = 0; j < BITS_PER_STAGE; j++) begin
        rem = rem_step(rem, div_shift[k-1][DIV_W-1-j], size);
      end
      div_rem_next[k] = rem;
    end
  end

  // Remainder pipeline registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
        div_valid[k] <= 1'b0;
      end
    end else begin
      if (div_mv[0]) begin
        div_valid[0] <= lookup.valid;
      end
      for (int k = 1; k <= DIV_STAGES; k++) begin
        if (div_mv[k]) begin
          div_valid[k] <= div_valid[k-1];
        end
      end
    end
    if (div_mv[0]) begin
      div_item[0]  <= item_in;
      div_shift[0] <= DIV_W'(loc_abs);
      div_rem[0]   <= '0;
    end
    for (int k = 1; k <= DIV_STAGES; k++) begin
      if (div_mv[k]) begin
        div_item[k]  <= div_item[k-1];
        div_shift[k] <= div_shift[k-1] << BITS_PER_STAGE;
        div_rem[k]   <= div_rem_next[k];
      end
    end
  end

  // Entry pair: a negative location folds back from the top of the palette;
  // the neighbor of the last entry in use is entry zero.
  always_comb begin
    if (div_item[DIV_STAGES].neg && div_rem[DIV_STAGES] != '0) begin
      idx1_full = size - div_rem[DIV_STAGES];
    end else begin
      idx1_full = div_rem[DIV_STAGES];
    end
    idx1_inc = idx1_full + CNT_W'(1);
    idx2_full = (idx1_inc >= size) ? '0 : idx1_inc;
  end

  assign ram_we = div_valid[DIV_STAGES] && (div_item[DIV_STAGES].cmd == CMD_WRITE) && mv_rd;

  // Two copies of the palette, written together, read at the entry pair.
  pgl_ram #(.WIDTH(RGB_W), .DEPTH(PALETTE_DEPTH)) u_ram_lo (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(div_item[DIV_STAGES].entry_index)),
    .wdata (div_item[DIV_STAGES].rgb),
    .re    (mv_rd),
    .raddr (idx1_full[ADDR_W-1:0]),
    .rdata (rd_c1)
  );

  pgl_ram #(.WIDTH(RGB_W), .DEPTH(PALETTE_DEPTH)) u_ram_hi (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(div_item[DIV_STAGES].entry_index)),
    .wdata (div_item[DIV_STAGES].rgb),
    .re    (mv_rd),
    .raddr (idx2_full[ADDR_W-1:0]),
    .rdata (rd_c2)
  );

  assign rd_t = transition(rd_frac);

  // Blend channels: a - t*a/255 + t*b/255, then scale by brightness.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mu_c[c] = mu_a[c] - div255(mu_pa[c]) + div255(mu_pb[c]);
    end
  end

  // Read, blend, scale and output registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      mu_valid <= 1'b0;
      sc_valid <= 1'b0;
      op_valid <= 1'b0;
    end else begin
      if (mv_rd) begin
        rd_valid <= div_valid[DIV_STAGES] && (div_item[DIV_STAGES].cmd == CMD_LOOKUP);
      end
      if (mv_mu) begin
        mu_valid <= rd_valid;
      end
      if (mv_sc) begin
        sc_valid <= mu_valid;
      end
      if (mv_op) begin
        op_valid <= sc_valid;
      end
    end
    if (mv_rd) begin
      rd_frac <= div_item[DIV_STAGES].frac;
    end
    for (int c = 0; c < 3; c++) begin
      if (mv_mu) begin
        mu_a[c]  <= rd_c1[RGB_W-1-c*COLOR_W -: COLOR_W];
        mu_pa[c] <= rd_t * rd_c1[RGB_W-1-c*COLOR_W -: COLOR_W];
        mu_pb[c] <= rd_t * rd_c2[RGB_W-1-c*COLOR_W -: COLOR_W];
      end
      if (mv_sc) begin
        sc_prod[c] <= brightness * mu_c[c];
      end
      if (mv_op) begin
        op_color[c] <= div255(sc_prod[c]);
      end
    end
  end

  // Result channel.
  assign color.valid     = op_valid;
  assign color.out_red   = op_color[0];
  assign color.out_green = op_color[1];
  assign color.out_blue  = op_color[2];

endmodule
